/* hw/rtl/double_ended_queue_assert.svh */
// Assertion macros for the deque block
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// check while out of reset
`define DEQUE_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every edge, reset included
`define DEQUE_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/deque_pkg.sv */
package deque_pkg;

   localparam int OPCODE_WIDTH = 3;
   localparam int VALUE_WIDTH  = 32;
   localparam int INDEX_WIDTH  = 10;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 11;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ_INDEX = 3'd4,
      OP_READ_FRONT = 3'd5,
      OP_READ_BACK  = 3'd6
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

/* hw/rtl/deque_ram.sv */
module deque_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/double_ended_queue.sv */
// Double-ended queue of fixed capacity, held in a ring buffer.
// Command channel: drive req_opcode, req_value and req_index with start high;
// the item is taken at any rising edge where start is high and busy is low.
// busy stays low, so one item can be taken every cycle.
// Operations: push front/back, pop front/back, read at an index from the
// front, read front, read back.
// Result channel: rsp_valid is high for exactly one cycle, the cycle right
// after the item was taken, with rsp_read_data, rsp_status and
// rsp_count. Throughput is one item per cycle, set by the single write port
// and single registered read port of the storage RAM.
// Pointer and count update at the edge that takes the item, so the next item
// sees the result of this one.
// The receiver cannot stall: each result must be taken in its strobe cycle.
// Reset empties the queue (head and count to zero); storage is not cleared,
// only entries written by a push are ever read.
module double_ended_queue
   import deque_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [OPCODE_WIDTH-1:0] req_opcode,
   input  logic [VALUE_WIDTH-1:0]  req_value,
   input  logic [INDEX_WIDTH-1:0]  req_index,
   output logic                    rsp_valid,
   output logic [VALUE_WIDTH-1:0]  rsp_read_data,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [COUNT_WIDTH-1:0]  rsp_count
);

   `include "double_ended_queue_assert.svh"

   localparam int PW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((PW > INDEX_WIDTH) ? PW : INDEX_WIDTH) + 1;

   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] head,
                                             input logic [EW-1:0] off);
      logic [EW-1:0] s;
      s = EW'(head) + off;
      if (s >= EW'(CAPACITY)) begin
         s = s - EW'(CAPACITY);
      end
      return s[PW-1:0];
   endfunction

   logic                  accept;
   op_type                op;
   logic                  full;
   logic                  empty;
   logic                  index_past_end;

   logic [PW-1:0]         head_ff,   head_in;
   logic [CW-1:0]         count_ff,  count_in;
   logic                  rsp_valid_ff;
   status_type            status_ff, status_in;
   logic                  rd_sel_ff;

   logic                  wr_en;
   logic [PW-1:0]         wr_addr;
   logic                  rd_en;
   logic [PW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = op_type'(req_opcode);
   assign full   = count_ff >= CW'(CAPACITY);
   assign empty  = count_ff == '0;
   assign index_past_end = EW'(req_index) >= EW'(count_ff);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      unique case (op)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               head_in  = (head_ff == '0) ? PW'(CAPACITY - 1) : head_ff - 1'b1;
               wr_en    = 1'b1;
               wr_addr  = head_in;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = slot_of(head_ff, EW'(count_ff));
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               head_in  = slot_of(head_ff, EW'(1));
               count_in = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         OP_READ_INDEX: begin
            if (index_past_end) begin
               status_in = ST_RANGE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, EW'(req_index));
            end
         end
         OP_READ_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_en = 1'b1;
            end
         end
         OP_READ_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, EW'(count_ff - 1'b1));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rd_sel_ff <= rd_en;
      end
   end

   deque_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (wr_addr),
      .wr_data (DATA_WIDTH'(req_value)),
      .rd_en   (accept && rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rd_sel_ff ? VALUE_WIDTH'(rd_data) : '0;
   assign rsp_status    = status_ff;
   assign rsp_count     = COUNT_WIDTH'(count_ff);

   `DEQUE_ASSERT_ALWAYS(a_rsp_one_per_item, !reset |-> (rsp_valid == ($past(accept) && !$past(reset))), "result strobe does not match a taken item")
   `DEQUE_ASSERT(a_count_bounded, count_ff <= CW'(CAPACITY), "count above capacity")
   `DEQUE_ASSERT(a_error_keeps_count, (rsp_valid && rsp_status != ST_OK) |-> (count_ff == $past(count_ff)), "failed operation changed count")
   `DEQUE_ASSERT(a_error_zero_data, (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_data == '0), "failed operation returned data")

endmodule
